// File: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Default timer width
  localparam int unsigned TimerBitsDef = 16;

  // Configuration register widths and port geometry
  localparam int unsigned DebounceW = 8;
  localparam int unsigned WindowW   = 12;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned PressMsW  = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWindow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLong     = 2'd2;

  // Register reset values
  localparam logic [DebounceW-1:0] DebounceRst = 8'd10;
  localparam logic [WindowW-1:0]   WindowRst   = 12'd300;
  localparam logic [LongW-1:0]     LongRst     = 16'd2000;

  // Result codes
  typedef enum logic [1:0] {
    KindSingle = 2'd0,
    KindDouble = 2'd1,
    KindLong   = 2'd2
  } press_kind_e;

  // Live configuration handed to the classifier core
  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [WindowW-1:0]   double_window_ms;
    logic [LongW-1:0]     long_press_ms;
  } bpc_cfg_t;

endpackage

// File: hw/rtl/bpc_cfg.sv
// ----------------------------------------------------------------------------
// bpc_cfg
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i,
  output bpc_pkg::bpc_cfg_t             cfg_o
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_q;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DebounceRst;
      cfg_q.double_window_ms <= WindowRst;
      cfg_q.long_press_ms    <= LongRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDebounce: cfg_q.debounce_ms      <= cfg_data_i[DebounceW-1:0];
        RegWindow:   cfg_q.double_window_ms <= cfg_data_i[WindowW-1:0];
        RegLong:     cfg_q.long_press_ms    <= cfg_data_i[LongW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// bpc_core
// Press state machine and saturating timers; one tick per step.
// ----------------------------------------------------------------------------
module bpc_core #(
  parameter int unsigned TimerBits = bpc_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          pin_high_i,
  input  bpc_pkg::bpc_cfg_t             cfg_i,
  output logic                          res_valid_o,
  output bpc_pkg::press_kind_e          res_kind_o,
  output logic [bpc_pkg::PressMsW-1:0]  res_ms_o
);
  import bpc_pkg::*;

  // Compare width: holds any timer plus a carry, and every register
  localparam int unsigned CmpW = ((TimerBits > PressMsW) ? TimerBits : PressMsW) + 1;
  localparam logic [TimerBits-1:0] TMax = {TimerBits{1'b1}};

  typedef enum logic [1:0] {
    StUp       = 2'd0,
    StDebounce = 2'd1,
    StDown     = 2'd2,
    StCool     = 2'd3
  } fsm_e;

  fsm_e                 fsm_q, fsm_d;
  logic [TimerBits-1:0] since_press_q, since_press_d;
  logic [TimerBits-1:0] since_deb_q, since_deb_d;
  logic [TimerBits-1:0] since_rel_q, since_rel_d;
  logic [TimerBits-1:0] since_pend_q, since_pend_d;
  logic [TimerBits-1:0] gap_q, gap_d;
  logic [TimerBits-1:0] held_q, held_d;
  logic                 pend_q, pend_d;

  logic                 pressed;
  logic [CmpW-1:0]      deb_x, win_x, long_x, held_x, wait_x, sum_x;
  logic [CmpW-1:0]      emit_x;

  function automatic logic [TimerBits-1:0] sat_inc(input logic [TimerBits-1:0] t);
    sat_inc = (t == TMax) ? t : t + 1'b1;
  endfunction

  function automatic logic [CmpW-1:0] tx(input logic [TimerBits-1:0] t);
    tx = {{(CmpW-TimerBits){1'b0}}, t};
  endfunction

  assign pressed = ~pin_high_i;
  assign deb_x   = {{(CmpW-DebounceW){1'b0}}, cfg_i.debounce_ms};
  assign win_x   = {{(CmpW-WindowW){1'b0}}, cfg_i.double_window_ms};
  assign long_x  = {{(CmpW-LongW){1'b0}}, cfg_i.long_press_ms};

  // Next state and result for the current tick
  always_comb begin
    since_press_d = sat_inc(since_press_q);
    since_deb_d   = sat_inc(since_deb_q);
    since_rel_d   = sat_inc(since_rel_q);
    since_pend_d  = sat_inc(since_pend_q);
    fsm_d         = fsm_q;
    gap_d         = gap_q;
    held_d        = held_q;
    pend_d        = pend_q;
    res_valid_o   = 1'b0;
    res_kind_o    = KindSingle;
    emit_x        = '0;
    sum_x         = tx(gap_q) + tx(since_press_d);

    case (fsm_q)
      StUp: begin
        if (pressed) begin
          fsm_d         = StDebounce;
          since_press_d = '0;
        end
      end
      StDebounce: begin
        if (!pressed) begin
          fsm_d = StUp;
        end else if (tx(since_press_d) >= deb_x) begin
          gap_d       = since_deb_d;
          since_deb_d = '0;
          fsm_d       = StDown;
        end
      end
      StDown: begin
        if (!pressed) begin
          held_d      = since_press_d;
          since_rel_d = '0;
          if (sum_x < win_x) begin
            // quick second press
            pend_d      = 1'b0;
            held_d      = '0;
            res_valid_o = 1'b1;
            res_kind_o  = KindDouble;
          end else begin
            since_pend_d = '0;
            pend_d       = 1'b1;
          end
          fsm_d = StCool;
        end else if (tx(since_press_d) >= long_x) begin
          held_d      = since_press_d;
          pend_d      = 1'b0;
          res_valid_o = 1'b1;
          res_kind_o  = KindLong;
          emit_x      = tx(since_press_d);
          fsm_d       = StCool;
        end
      end
      StCool: begin
        if (tx(since_rel_d) >= deb_x && !pressed) begin
          fsm_d = StUp;
        end
      end
      default: fsm_d = StUp;
    endcase

    // Pending single press: wait |window - duration|
    held_x = tx(held_d);
    wait_x = (win_x >= held_x) ? win_x - held_x : held_x - win_x;
    if (pend_d && !res_valid_o && tx(since_pend_d) >= wait_x) begin
      pend_d      = 1'b0;
      res_valid_o = 1'b1;
      res_kind_o  = KindSingle;
      emit_x      = held_x;
    end

    // Saturate duration to the result width
    res_ms_o = (emit_x > CmpW'({PressMsW{1'b1}})) ? {PressMsW{1'b1}}
                                                   : emit_x[PressMsW-1:0];
    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q         <= StUp;
      since_press_q <= '0;
      since_deb_q   <= TMax;
      since_rel_q   <= TMax;
      since_pend_q  <= '0;
      gap_q         <= TMax;
      held_q        <= '0;
      pend_q        <= 1'b0;
    end else if (step_i) begin
      fsm_q         <= fsm_d;
      since_press_q <= since_press_d;
      since_deb_q   <= since_deb_d;
      since_rel_q   <= since_rel_d;
      since_pend_q  <= since_pend_d;
      gap_q         <= gap_d;
      held_q        <= held_d;
      pend_q        <= pend_d;
    end
  end

  // Checks
  a_res_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i) else $error("result without a tick");
  a_double_zero_ms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_kind_o == KindDouble) |-> res_ms_o == '0)
    else $error("double press with non-zero duration");
  a_hold_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(fsm_q) && $stable(pend_q) && $stable(since_press_q)))
    else $error("state moved without a tick");
  a_long_leaves_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_kind_o == KindLong) |=> fsm_q == StCool)
    else $error("long press did not enter cooldown");

endmodule

// File: hw/rtl/button_press_classifier.sv
// Path: a tick word taken into the input register goes through the core, and
// its result word is captured in the result register that feeds the outputs.
// Throughput: one tick word per cycle unless in_stall_o is high, limited by
// the single state update pass. An input register and a result register part
// the two sides, so a tick is taken while a finished result waits downstream.
// Reset (rst_ni low, asynchronous): state machine at key up, timers and
// registers at their defaults, both word registers empty.
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced single, double and long press classifier on millisecond ticks.
// ----------------------------------------------------------------------------
module button_press_classifier #(
  parameter int unsigned TimerBits = bpc_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          pin_high_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    press_kind_o,
  output logic [bpc_pkg::PressMsW-1:0]  press_ms_o
);
  import bpc_pkg::*;

  bpc_cfg_t              cfg;
  logic                  in_valid_q, pin_q;
  logic                  out_valid_q;
  press_kind_e           kind_q;
  logic [PressMsW-1:0]   ms_q;
  logic                  advance, step, in_take;
  logic                  res_valid;
  press_kind_e           res_kind;
  logic [PressMsW-1:0]   res_ms;

  bpc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: result register free or draining lets the input word move on
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q <= pin_high_i;
    end
  end

  bpc_core #(
    .TimerBits (TimerBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_high_i  (pin_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind),
    .res_ms_o    (res_ms)
  );

  // Result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      kind_q <= res_kind;
      ms_q   <= res_ms;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign press_kind_o = kind_q;
  assign press_ms_o   = ms_q;

  // Checks
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room to move");
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && !$past(step)))
    else $error("tick processed while result word blocked");
  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> (!out_valid_q || $past(out_valid_q && out_stall_i)))
    else $error("result word appeared without a tick");

endmodule
